// ===== hdl/jad_pkg.sv =====
// Shared constants, register codes and pipeline types of the joystick axis deadzone block.
`timescale 1ns / 1ps
package jad_pkg;

  localparam int SB       = 16;                 // sample width
  localparam int FS       = 2**(SB-1) - 1;      // full scale
  localparam int LEN_FRAC = 24 - SB;            // fraction bits of the vector length
  localparam int ONE_Q15  = 32768;
  localparam int SIZE_W   = 15;
  localparam int MODE_W   = 2;
  localparam int NAXIS    = 4;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 15;

  localparam int DATA_W = ((3*SB + 7) / 8) * 8;
  localparam int SQW    = 2*SB;
  localparam int VW     = 2*SB + 2*LEN_FRAC;    // radicand width
  localparam int LENW   = VW / 2;
  localparam int THR0W  = SIZE_W + SB - 1;
  localparam int THRW   = THR0W + LEN_FRAC;
  localparam int GW     = LENW + 15;
  localparam int DW     = LENW + 16;
  localparam int NUMW   = SB + GW;
  localparam int NW     = NUMW + 2;
  localparam int RT_N   = VW / 2;               // square root stages
  localparam int DV_N   = SB;                   // quotient stages

  typedef enum logic [MODE_W-1:0] {
    MODE_RAW   = 2'd0,
    MODE_INDEP = 2'd1,
    MODE_CIRC  = 2'd2
  } mode_t;

  localparam logic [CFG_AW-1:0] REG_MODE_AXIS0 = 3'd0;
  localparam logic [CFG_AW-1:0] REG_SIZE_AXIS0 = 3'd4;

  localparam logic [NAXIS-1:0][SIZE_W-1:0] SIZE_RESET = {15'd3932, 15'd3932, 15'd8847, 15'd7864};

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [SIZE_W-1:0] size;
  } axis_cfg_t;

  typedef struct packed {
    logic [MODE_W-1:0]       mode;
    logic [SIZE_W-1:0]       size;
    logic [2:0][SB-1:0]      c;
    logic [2:0][SB-1:0]      a;
    logic [THR0W-1:0]        thr0;
    logic [2:0]              kill;
    logic [2:0][SQW-1:0]     sq;
    logic [THRW-1:0]         thr;
    logic [VW-1:0]           rem;
    logic [VW-1:0]           res;
    logic                    zero;
    logic [GW-1:0]           gain;
    logic [DW-1:0]           den;
    logic [2:0][NW-1:0]      nrem;
    logic [NW-1:0]           dd;
    logic [2:0][SB-1:0]      q;
    logic [2:0]              ovf;
  } stage_t;

endpackage

// ===== hdl/joystick_axis_deadzone_core.sv =====
// Top level: pipelined joystick axis deadzone with square root and quotient stages.
//
//   channel  ports              contents
//   input    in_t*  (request)   tuser: axis_index; tdata: in_x, in_y, in_z
//   output   out_t* (request)   tdata: out_x, out_y, out_z
//   config   cfg_we/addr/wdata  mode_axis0..3, size_axis0..3
//
// One request per cycle while the output does not stall, through 48 register stages (24 square root
// steps, 16 quotient steps); each result is offered from the last stage.
// Each stage holds only while it is full and the stage after it holds, so bubbles
// collapse; a stalled result holds off requests only once every stage is full.
// Reset clears the stage valid bits and loads the register reset values.
`timescale 1ns / 1ps
module joystick_axis_deadzone_core import jad_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [DATA_W-1:0] in_tdata,   // in_x, in_y, in_z
  input  logic [1:0]        in_tuser,   // axis_index
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [DATA_W-1:0] out_tdata,  // out_x, out_y, out_z
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  localparam int ST_IN  = 0;
  localparam int ST_SQ  = 1;
  localparam int ST_SUM = 2;
  localparam int ST_RT0 = 3;
  localparam int ST_GN  = ST_RT0 + RT_N;
  localparam int ST_MU  = ST_GN + 1;
  localparam int ST_ND  = ST_MU + 1;
  localparam int ST_OV  = ST_ND + 1;
  localparam int ST_DV0 = ST_OV + 1;
  localparam int ST_OUT = ST_DV0 + DV_N;
  localparam int NST    = ST_OUT + 1;

  axis_cfg_t           sel;
  logic [NST-1:0]      v_r;
  stage_t              pay_r [NST];
  stage_t              pay_nxt [NST];
  logic [NST:0]        rdy;

  jad_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .axis      (in_tuser),
    .sel       (sel)
  );

  assign rdy[NST]   = out_tready;
  assign in_tready  = rdy[ST_IN];
  assign out_tvalid = v_r[ST_OUT];
  assign out_tdata  = DATA_W'(pay_r[ST_OUT].c);

  // capture, axis lookup, magnitudes, threshold
  always_comb begin
    pay_nxt[ST_IN]      = pay_r[ST_IN];
    pay_nxt[ST_IN].mode = sel.mode;
    pay_nxt[ST_IN].size = sel.size;
    pay_nxt[ST_IN].c    = in_tdata[3*SB-1:0];
    for (int i = 0; i < 3; i++) begin
      pay_nxt[ST_IN].a[i] = in_tdata[i*SB + SB-1] ? SB'(-$signed(in_tdata[i*SB +: SB]))
                                                  : in_tdata[i*SB +: SB];
    end
    pay_nxt[ST_IN].thr0 = THR0W'(sel.size) * THR0W'(FS);
  end

  genvar k;
  for (k = 0; k < NST; k++) begin : g_stage
    assign rdy[k] = !v_r[k] || rdy[k+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_r[k] <= (k == ST_IN) ? in_tvalid : v_r[(k == ST_IN) ? 0 : k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k]) begin
        pay_r[k] <= pay_nxt[k];
      end
    end

    if (k == ST_SQ) begin : g_sq
      always_comb begin
        pay_nxt[k] = pay_r[k-1];
        for (int i = 0; i < 3; i++) begin
          pay_nxt[k].sq[i]   = SQW'(pay_r[k-1].a[i]) * SQW'(pay_r[k-1].a[i]);
          pay_nxt[k].kill[i] = {pay_r[k-1].a[i], 15'b0} < (SB+15)'(pay_r[k-1].thr0);
        end
      end
    end else if (k == ST_SUM) begin : g_sum
      logic [SQW+1:0] sum;
      always_comb begin
        pay_nxt[k] = pay_r[k-1];
        sum = (SQW+2)'(pay_r[k-1].sq[0]) + (SQW+2)'(pay_r[k-1].sq[1])
            + (SQW+2)'(pay_r[k-1].sq[2]);
        pay_nxt[k].rem = VW'(sum[SQW-1:0]) << (2*LEN_FRAC);
        pay_nxt[k].res = '0;
        pay_nxt[k].thr = THRW'(pay_r[k-1].thr0) << LEN_FRAC;
      end
    end else if (k >= ST_RT0 && k < ST_GN) begin : g_rt
      localparam int SH = VW - 2 - 2*(k - ST_RT0);
      localparam logic [VW-1:0] BITV = VW'(1) << SH;
      logic [VW-1:0] t;
      always_comb begin
        pay_nxt[k] = pay_r[k-1];
        t = pay_r[k-1].res + BITV;
        if (pay_r[k-1].rem >= t) begin
          pay_nxt[k].rem = pay_r[k-1].rem - t;
          pay_nxt[k].res = (pay_r[k-1].res >> 1) + BITV;
        end else begin
          pay_nxt[k].res = pay_r[k-1].res >> 1;
        end
      end
    end else if (k == ST_GN) begin : g_gn
      logic [LENW-1:0] len;
      logic [GW-1:0]   lq;
      logic [GW-1:0]   thrx;
      logic [15:0]     span;
      always_comb begin
        pay_nxt[k] = pay_r[k-1];
        len  = pay_r[k-1].res[LENW-1:0];
        lq   = {len, 15'b0};
        thrx = GW'(pay_r[k-1].thr);
        span = 16'(ONE_Q15) - 16'(pay_r[k-1].size);
        pay_nxt[k].zero = (len == '0) || (lq < thrx);
        pay_nxt[k].gain = lq - thrx;
        pay_nxt[k].den  = DW'(len) * DW'(span);
      end
    end else if (k == ST_MU) begin : g_mu
      always_comb begin
        pay_nxt[k] = pay_r[k-1];
        for (int i = 0; i < 3; i++) begin
          pay_nxt[k].nrem[i] = NW'(NUMW'(pay_r[k-1].a[i]) * NUMW'(pay_r[k-1].gain));
        end
      end
    end else if (k == ST_ND) begin : g_nd
      always_comb begin
        pay_nxt[k] = pay_r[k-1];
        // round half away: (2*num + den) / (2*den)
        for (int i = 0; i < 3; i++) begin
          pay_nxt[k].nrem[i] = (pay_r[k-1].nrem[i] << 1) + NW'(pay_r[k-1].den);
        end
        pay_nxt[k].dd = NW'({pay_r[k-1].den, 1'b0});
      end
    end else if (k == ST_OV) begin : g_ov
      always_comb begin
        pay_nxt[k] = pay_r[k-1];
        for (int i = 0; i < 3; i++) begin
          pay_nxt[k].ovf[i] = pay_r[k-1].nrem[i] >= (pay_r[k-1].dd << SB);
        end
        pay_nxt[k].q = '0;
      end
    end else if (k >= ST_DV0 && k < ST_OUT) begin : g_dv
      localparam int SH = SB - 1 - (k - ST_DV0);
      logic [NW-1:0] sh;
      always_comb begin
        pay_nxt[k] = pay_r[k-1];
        sh = pay_r[k-1].dd << SH;
        for (int i = 0; i < 3; i++) begin
          if (pay_r[k-1].nrem[i] >= sh) begin
            pay_nxt[k].nrem[i]  = pay_r[k-1].nrem[i] - sh;
            pay_nxt[k].q[i][SH] = 1'b1;
          end
        end
      end
    end else if (k == ST_OUT) begin : g_out
      logic [SB-1:0] mag;
      logic [SB-1:0] circ;
      always_comb begin
        pay_nxt[k] = pay_r[k-1];
        mag  = '0;
        circ = '0;
        for (int i = 0; i < 3; i++) begin
          // clamp the quotient to FS + 1, then apply the sign and saturate
          if (pay_r[k-1].ovf[i] || pay_r[k-1].q[i] > SB'(FS + 1)) begin
            mag = SB'(FS + 1);
          end else begin
            mag = pay_r[k-1].q[i];
          end
          if (pay_r[k-1].c[i][SB-1]) begin
            circ = SB'(-mag);
          end else if (mag > SB'(FS)) begin
            circ = SB'(FS);
          end else begin
            circ = mag;
          end
          if (pay_r[k-1].zero) circ = '0;
          case (pay_r[k-1].mode)
            MODE_INDEP: pay_nxt[k].c[i] = pay_r[k-1].kill[i] ? '0 : pay_r[k-1].c[i];
            MODE_CIRC:  pay_nxt[k].c[i] = circ;
            default:    pay_nxt[k].c[i] = pay_r[k-1].c[i];
          endcase
        end
      end
    end
  end

endmodule

// ===== hdl/jad_cfg.sv =====
// Per-axis deadzone registers and the lookup of the selected axis.
`timescale 1ns / 1ps
module jad_cfg import jad_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata,
  input  logic [1:0]        axis,
  output axis_cfg_t         sel
);

  logic [NAXIS-1:0][MODE_W-1:0] mode_r;
  logic [NAXIS-1:0][SIZE_W-1:0] size_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NAXIS; i++) begin
        mode_r[i] <= MODE_CIRC;
        size_r[i] <= SIZE_RESET[i];
      end
    end else if (cfg_we) begin
      for (int i = 0; i < NAXIS; i++) begin
        if (cfg_addr == REG_MODE_AXIS0 + CFG_AW'(i)) mode_r[i] <= cfg_wdata[MODE_W-1:0];
        if (cfg_addr == REG_SIZE_AXIS0 + CFG_AW'(i)) size_r[i] <= cfg_wdata[SIZE_W-1:0];
      end
    end
  end

  assign sel.mode = mode_r[axis];
  assign sel.size = size_r[axis];

endmodule

// ===== tb/sv/tb_joystick_axis_deadzone_core.sv =====
// Testbench of the joystick axis deadzone core: directed and random samples against a predictor.
`timescale 1ns / 1ps
module tb_joystick_axis_deadzone_core;
  import jad_pkg::*;

  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;  // unused code, behaves as raw
  localparam int DRAIN_CYCLES = 70;                 // pipeline is 48 deep

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [DATA_W-1:0] in_tdata = '0;   // in_x, in_y, in_z
  logic [1:0]        in_tuser = '0;   // axis_index
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [DATA_W-1:0] out_tdata;       // out_x, out_y, out_z
  logic              cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [CFG_DW-1:0] cfg_wdata = '0;

  // Shadow copy of the axis registers
  logic [MODE_W-1:0] axis_mode [NAXIS];
  logic [SIZE_W-1:0] axis_size [NAXIS];

  logic [DATA_W-1:0] pending_samples [$];
  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;

  joystick_axis_deadzone_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  function automatic logic [DATA_W-1:0] condition_sample(logic [1:0] ax,
                                                          logic [DATA_W-1:0] raw);
    longint signed   c [3];
    longint signed   r [3];
    longint unsigned a [3];
    longint unsigned s, v, len, bitv, thr, gain, den, num, q, sz;
    logic [DATA_W-1:0] o;
    sz = axis_size[ax];
    for (int i = 0; i < 3; i++) begin
      c[i] = longint'($signed(raw[i*SB +: SB]));
      a[i] = (c[i] < 0) ? -c[i] : c[i];
      r[i] = c[i];
    end
    if (axis_mode[ax] == MODE_INDEP) begin
      for (int i = 0; i < 3; i++)
        if (a[i] * ONE_Q15 < sz * FS) r[i] = 0;
    end else if (axis_mode[ax] == MODE_CIRC) begin
      s = a[0]*a[0] + a[1]*a[1] + a[2]*a[2];
      v = s << (2*LEN_FRAC);
      thr = (sz * FS) << LEN_FRAC;
      len = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
        if (v >= len + bitv) begin
          v -= len + bitv;
          len = (len >> 1) + bitv;
        end else begin
          len >>= 1;
        end
        bitv >>= 2;
      end
      if (len == 0 || len * ONE_Q15 < thr) begin
        for (int i = 0; i < 3; i++) r[i] = 0;
      end else begin
        gain = len * ONE_Q15 - thr;
        den = len * (ONE_Q15 - sz);
        for (int i = 0; i < 3; i++) begin
          num = a[i] * gain;
          q = (2*num + den) / (2*den);
          if (q > FS + 1) q = FS + 1;
          r[i] = (c[i] < 0) ? -longint'(q) : longint'(q);
        end
      end
    end
    for (int i = 0; i < 3; i++) begin
      if (r[i] > FS) r[i] = FS;
      if (r[i] < -FS - 1) r[i] = -FS - 1;
      o[i*SB +: SB] = r[i][SB-1:0];
    end
    return o;
  endfunction

  // Result checker: sample at the falling edge, where the handshake is settled
  always @(negedge clk) begin
    logic [DATA_W-1:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_tdata);
      end else begin
        want = pending_samples.pop_front();
        for (int i = 0; i < 3; i++)
          if (out_tdata[i*SB +: SB] !== want[i*SB +: SB]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("component %0d: expected %0d, got %0d", i,
                       $signed(want[i*SB +: SB]), $signed(out_tdata[i*SB +: SB]));
          end
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_sample(logic [1:0] ax, logic [SB-1:0] x, logic [SB-1:0] y,
                             logic [SB-1:0] z);
    bit taken;
    taken = 1'b0;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= ax;
    in_tdata <= {z, y, x};
    while (!taken) begin
      @(negedge clk);
      if (in_tready) begin
        taken = 1'b1;
        pending_samples.push_back(condition_sample(ax, {z, y, x}));
      end
      @(posedge clk);
    end
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx < CFG_AW'(NAXIS)) axis_mode[idx[1:0]] = val[MODE_W-1:0];
    else axis_size[idx[1:0]] = val[SIZE_W-1:0];
    @(posedge clk);
  endtask

  task automatic program_axis(int ax, logic [MODE_W-1:0] m, logic [SIZE_W-1:0] sz);
    write_reg(REG_MODE_AXIS0 + CFG_AW'(ax), CFG_DW'(m));
    write_reg(REG_SIZE_AXIS0 + CFG_AW'(ax), sz);
  endtask

  function automatic logic [SB-1:0] random_component();
    case ($urandom_range(5))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'($signed($urandom_range(600)) - 300);
      3: return 16'($signed($urandom_range(20000)) - 10000);
      default: return SB'($urandom());
    endcase
  endfunction

  function automatic logic [SIZE_W-1:0] random_size();
    case ($urandom_range(4))
      0: return '0;
      1: return 15'd32766;
      2: return 15'd32767;
      default: return SIZE_W'($urandom_range(32766));
    endcase
  endfunction

  task automatic send_extremes(logic [1:0] ax);
    send_sample(ax, 16'h0000, 16'h0000, 16'h0000);
    send_sample(ax, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_sample(ax, 16'h8000, 16'h8000, 16'h8000);
    send_sample(ax, 16'h7FFF, 16'h8000, 16'h0001);
    send_sample(ax, 16'd1000, 16'hFC18, 16'd0);
  endtask

  // Reset values: circular on every axis, vectors inside and outside the zone
  task automatic test_reset_values;
    for (int ax = 0; ax < NAXIS; ax++) begin
      axis_mode[ax] = MODE_CIRC;
      axis_size[ax] = SIZE_RESET[ax];
    end
    send_extremes(2'd0);
    send_sample(2'd1, 16'd5000, 16'd5000, 16'd0);
    send_sample(2'd2, 16'd3000, 16'd0, 16'd0);
    send_sample(2'd3, 16'hFFFF, 16'd0, 16'd0);
    drain();
  endtask

  // Raw, independent and the spare code, at both size extremes
  task automatic test_modes;
    program_axis(0, MODE_RAW, 15'd32766);
    program_axis(1, MODE_INDEP, 15'd0);
    program_axis(2, MODE_INDEP, 15'd32766);
    program_axis(3, MODE_SPARE, 15'd100);
    for (int ax = 0; ax < NAXIS; ax++) send_extremes(2'(ax));
    send_sample(2'd2, 16'h7FFE, 16'h8001, 16'h7FFF);
    drain();
  endtask

  // Circular mode: no zone, half zone, nearly full zone, and the out-of-range size
  task automatic test_circular_sizes;
    program_axis(0, MODE_CIRC, 15'd0);
    program_axis(1, MODE_CIRC, 15'd32766);
    program_axis(2, MODE_CIRC, 15'd32767);
    program_axis(3, MODE_CIRC, 15'd16384);
    for (int ax = 0; ax < NAXIS; ax++) send_extremes(2'(ax));
    drain();
  endtask

  task automatic test_random(int n_items);
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 7 : (ph == 1) ? 88 : 0;
      recv_idle_pct = (ph == 0) ? 88 : (ph == 1) ? 7 : 0;
      for (int k = 0; k < 2; k++) begin
        for (int ax = 0; ax < NAXIS; ax++)
          program_axis(ax, MODE_W'($urandom_range(3)), random_size());
        for (int i = 0; i < n_items / 6; i++)
          send_sample(2'($urandom_range(3)), random_component(), random_component(),
                      random_component());
        drain();
      end
    end
  endtask

  // Hold the receiver off long enough for the pipeline to fill and stall the input
  task automatic test_backpressure;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req++;
    for (int i = 0; i < 150; i++)
      send_sample(2'($urandom_range(3)), SB'($urandom()), SB'($urandom()),
                  SB'($urandom()));
    drain();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_values();
    test_modes();
    test_circular_sizes();
    test_backpressure();
    test_random(1740);
    if (mismatches == 0) begin
      $display("tb_joystick_axis_deadzone_core: done, clean");
    end else begin
      $display("tb_joystick_axis_deadzone_core: done, errors");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("tb_joystick_axis_deadzone_core: done, errors");
    $finish;
  end

endmodule
